// ----- hdl/assert_macros.svh -----
// assertion macros shared by the overlap suppressor modules
// no dependencies; taken in by `include where a module checks itself

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/csbos_pkg.sv -----
// shared types and constants of the cross-set box overlap suppressor
// no dependencies; used by every module of the block
`default_nettype none

package csbos_pkg;

	localparam int COORD_BITS = 12;
	localparam int AREA_BITS  = 2 * COORD_BITS;
	localparam int UNI_BITS   = AREA_BITS + 1;
	localparam int THR_BITS   = 8;
	localparam int CMP_BITS   = THR_BITS + UNI_BITS;
	localparam int MATCH_BITS = 4;
	localparam int Q_DEPTH    = 2;

	localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(64);

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_TEST  = 2'd2;

	typedef enum logic [1:0] {
		KIND_CLEAR,
		KIND_ADD,
		KIND_TEST
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEARED    = 3'd0,
		ST_ADDED      = 3'd1,
		ST_FULL       = 3'd2,
		ST_KEPT       = 3'd3,
		ST_SUPPRESSED = 3'd4
	} status_t;

	typedef enum logic {
		BK_IDLE,
		BK_WALK
	} bk_state_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] w;
		logic [COORD_BITS-1:0] h;
	} box_t;

	typedef struct packed {
		logic [1:0]            opcode;
		logic [COORD_BITS-1:0] box_x;
		logic [COORD_BITS-1:0] box_y;
		logic [COORD_BITS-1:0] box_width;
		logic [COORD_BITS-1:0] box_height;
	} in_item_t;

	typedef struct packed {
		logic [2:0]            status;
		logic [MATCH_BITS-1:0] match_index;
		logic [COORD_BITS-1:0] out_x;
		logic [COORD_BITS-1:0] out_y;
		logic [COORD_BITS-1:0] out_width;
		logic [COORD_BITS-1:0] out_height;
	} out_item_t;

	// one classified command in the queue
	typedef struct packed {
		kind_t                kind;
		box_t                 box;
		logic [AREA_BITS-1:0] area;
	} cmd_t;

	// one stored reference box with its area
	typedef struct packed {
		box_t                 box;
		logic [AREA_BITS-1:0] area;
	} ref_entry_t;

endpackage

`default_nettype wire

// ----- hdl/csbos_front.sv -----
// front end: accepts beats, decodes the opcode and computes the box area
// depends on csbos_pkg
`default_nettype none

module csbos_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  csbos_pkg::in_item_t item,
	input  logic                full,
	output logic                push,
	output csbos_pkg::cmd_t     cmd
);

	logic                valid_s1;
	csbos_pkg::in_item_t item_s1;
	csbos_pkg::kind_t    kind;
	logic                accept;

	assign busy   = valid_s1 & full;
	assign accept = start & ~busy;
	assign push   = valid_s1 & ~full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// unused opcode value is treated as a test
	always_comb begin
		case (item_s1.opcode)
			csbos_pkg::OP_CLEAR: kind = csbos_pkg::KIND_CLEAR;
			csbos_pkg::OP_ADD:   kind = csbos_pkg::KIND_ADD;
			csbos_pkg::OP_TEST:  kind = csbos_pkg::KIND_TEST;
			default:             kind = csbos_pkg::KIND_TEST;
		endcase
	end

	assign cmd.kind  = kind;
	assign cmd.box.x = item_s1.box_x;
	assign cmd.box.y = item_s1.box_y;
	assign cmd.box.w = item_s1.box_width;
	assign cmd.box.h = item_s1.box_height;
	assign cmd.area  = csbos_pkg::AREA_BITS'(item_s1.box_width) *
		csbos_pkg::AREA_BITS'(item_s1.box_height);

endmodule

`default_nettype wire

// ----- hdl/csbos_queue.sv -----
// short command queue between the front end and the table engine
// depends on csbos_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module csbos_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  csbos_pkg::cmd_t   push_data,
	output logic              full,
	input  logic              pop,
	output csbos_pkg::cmd_t   head,
	output logic              empty
);

	localparam int DEPTH    = csbos_pkg::Q_DEPTH;
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	csbos_pkg::cmd_t     entry_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] cnt_q;

	assign full  = (cnt_q == CNT_BITS'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`ASSERT_IMPLIES(a_no_push_full, clk, arst_n, push, !full, "push into a full queue")
	`ASSERT_IMPLIES(a_no_pop_empty, clk, arst_n, pop, !empty, "pop from an empty queue")
	`ASSERT_IMPLIES(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_BITS'(DEPTH), "queue overfilled")

endmodule

`default_nettype wire

// ----- hdl/csbos_back.sv -----
// table engine: reference box memory, pipelined overlap walk, result register
// depends on csbos_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module csbos_back #(
	parameter int MAX_REFS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [csbos_pkg::THR_BITS-1:0]      thr,
	input  logic                                empty,
	input  csbos_pkg::cmd_t                     head,
	output logic                                pop,
	output logic                                done,
	output csbos_pkg::out_item_t                result
);

	localparam int CNT_BITS = $clog2(MAX_REFS + 1);
	localparam int IDX_BITS = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
	localparam int CB       = csbos_pkg::COORD_BITS;
	localparam int AB       = csbos_pkg::AREA_BITS;
	localparam int UB       = csbos_pkg::UNI_BITS;
	localparam int TB       = csbos_pkg::THR_BITS;
	localparam int PB       = csbos_pkg::CMP_BITS;

	// overlap of two spans, zero when disjoint or touching
	function automatic logic [CB-1:0] span_overlap(
		input logic [CB-1:0] a0,
		input logic [CB-1:0] alen,
		input logic [CB-1:0] b0,
		input logic [CB-1:0] blen
	);
		logic [CB:0] a1;
		logic [CB:0] b1;
		logic [CB:0] lo;
		logic [CB:0] hi;
		a1 = {1'b0, a0} + {1'b0, alen};
		b1 = {1'b0, b0} + {1'b0, blen};
		lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
		hi = (a1 < b1) ? a1 : b1;
		return (hi > lo) ? CB'(hi - lo) : '0;
	endfunction

	csbos_pkg::bk_state_t  state_q;
	csbos_pkg::bk_state_t  state_d;
	logic [CNT_BITS-1:0]   count_q;
	logic [CNT_BITS-1:0]   iss_idx_q;
	logic                  issue_q;
	logic                  iss_last;
	csbos_pkg::cmd_t       cand_q;
	csbos_pkg::ref_entry_t ref_mem [MAX_REFS];

	logic                  clr;
	logic                  add_ok;
	logic                  start_walk;
	logic                  finish;
	logic                  done_d;
	csbos_pkg::out_item_t  res_d;
	logic                  done_q;
	csbos_pkg::out_item_t  result_q;

	csbos_pkg::ref_entry_t ent_s1;
	logic [IDX_BITS-1:0]   idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic                  last_s1, last_s2, last_s3, last_s4, last_s5;
	logic                  v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [CB-1:0]         ix_s2;
	logic [CB-1:0]         iy_s2;
	logic [AB-1:0]         barea_s2, barea_s3;
	logic [AB-1:0]         inter_s3, inter_s4, inter_s5;
	logic [UB-1:0]         uni_s4;
	logic [PB-1:0]         tu_s5;
	logic                  hit;

	assign iss_last = (iss_idx_q == count_q - 1'b1);
	assign hit      = v_s5 && (PB'({inter_s5, {TB{1'b0}}}) > tu_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csbos_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d              = state_q;
		pop                  = 1'b0;
		clr                  = 1'b0;
		add_ok               = 1'b0;
		start_walk           = 1'b0;
		finish               = 1'b0;
		done_d               = 1'b0;
		res_d.status         = csbos_pkg::ST_KEPT;
		res_d.match_index    = '0;
		res_d.out_x          = head.box.x;
		res_d.out_y          = head.box.y;
		res_d.out_width      = head.box.w;
		res_d.out_height     = head.box.h;
		case (state_q)
			csbos_pkg::BK_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					case (head.kind)
						csbos_pkg::KIND_CLEAR: begin
							clr          = 1'b1;
							done_d       = 1'b1;
							res_d.status = csbos_pkg::ST_CLEARED;
						end
						csbos_pkg::KIND_ADD: begin
							done_d = 1'b1;
							if (count_q < CNT_BITS'(MAX_REFS)) begin
								add_ok       = 1'b1;
								res_d.status = csbos_pkg::ST_ADDED;
							end else begin
								res_d.status = csbos_pkg::ST_FULL;
							end
						end
						default: begin
							if (count_q == '0) begin
								done_d = 1'b1;
							end else begin
								start_walk = 1'b1;
								state_d    = csbos_pkg::BK_WALK;
							end
						end
					endcase
				end
			end
			csbos_pkg::BK_WALK: begin
				res_d.out_x      = cand_q.box.x;
				res_d.out_y      = cand_q.box.y;
				res_d.out_width  = cand_q.box.w;
				res_d.out_height = cand_q.box.h;
				if (hit) begin
					done_d            = 1'b1;
					finish            = 1'b1;
					res_d.status      = csbos_pkg::ST_SUPPRESSED;
					res_d.match_index = csbos_pkg::MATCH_BITS'(idx_s5);
					state_d           = csbos_pkg::BK_IDLE;
				end else if (v_s5 && last_s5) begin
					done_d  = 1'b1;
					finish  = 1'b1;
					state_d = csbos_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = csbos_pkg::BK_IDLE;
			end
		endcase
	end

	// table memory: one write port for adds, one registered read port for the walk
	always_ff @(posedge clk) begin
		if (add_ok) begin
			ref_mem[count_q[IDX_BITS-1:0]] <= '{box: head.box, area: head.area};
		end
		ent_s1 <= ref_mem[iss_idx_q[IDX_BITS-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			issue_q   <= 1'b0;
			iss_idx_q <= '0;
		end else begin
			if (clr) begin
				count_q <= '0;
			end else if (add_ok) begin
				count_q <= count_q + 1'b1;
			end
			if (start_walk) begin
				issue_q   <= 1'b1;
				iss_idx_q <= '0;
			end else if (finish) begin
				issue_q <= 1'b0;
			end else if (issue_q) begin
				iss_idx_q <= iss_idx_q + 1'b1;
				if (iss_last) begin
					issue_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_walk) begin
			cand_q <= head;
		end
	end

	// walk pipeline valids, flushed when the walk ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (finish) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= issue_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= iss_idx_q[IDX_BITS-1:0];
		last_s1  <= iss_last;
		// spans of the intersection
		ix_s2    <= span_overlap(cand_q.box.x, cand_q.box.w, ent_s1.box.x, ent_s1.box.w);
		iy_s2    <= span_overlap(cand_q.box.y, cand_q.box.h, ent_s1.box.y, ent_s1.box.h);
		barea_s2 <= ent_s1.area;
		idx_s2   <= idx_s1;
		last_s2  <= last_s1;
		// intersection area
		inter_s3 <= AB'(ix_s2) * AB'(iy_s2);
		barea_s3 <= barea_s2;
		idx_s3   <= idx_s2;
		last_s3  <= last_s2;
		// union area
		uni_s4   <= UB'(cand_q.area) + UB'(barea_s3) - UB'(inter_s3);
		inter_s4 <= inter_s3;
		idx_s4   <= idx_s3;
		last_s4  <= last_s3;
		// threshold times union
		tu_s5    <= PB'(thr) * PB'(uni_s4);
		inter_s5 <= inter_s4;
		idx_s5   <= idx_s4;
		last_s5  <= last_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

	assign done   = done_q;
	assign result = result_q;

	`ASSERT_NEXT(a_pop_resolves, clk, arst_n, pop, done_q || state_q == csbos_pkg::BK_WALK, "popped command neither answered nor walking")
	`ASSERT_IMPLIES(a_walk_nonempty, clk, arst_n, state_q == csbos_pkg::BK_WALK, count_q != '0, "walk over an empty table")
	`ASSERT_IMPLIES(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_BITS'(MAX_REFS), "table count beyond depth")

endmodule

`default_nettype wire

// ----- hdl/cross_set_box_overlap_suppress.sv -----
// top level of the cross-set box overlap suppressor: threshold register and wiring
// depends on csbos_pkg, csbos_front, csbos_queue and csbos_back
`default_nettype none

// channel    | handshake                  | payload
// -----------+----------------------------+--------------------------
// command in | start, busy (beat: start & !busy) | item (in_item_t)
// result out | done strobe, one cycle     | result (out_item_t)
// threshold  | cfg_wen, written each edge | cfg_wdata (8 bits)
//
// clear and add: strobed from the result register once the engine pops the command
// test: a stored box enters the compare pipeline every cycle from the table's
//   single read port; the strobe reports the first matching index on a hit,
//   or follows the last stored box when kept; the engine pops nothing while walking
// a front register and a two-deep queue hold up to three commands while a walk runs
// arst_n clears the table count, the queue and the threshold (back to 64)
// busy rises only when the front register and the queue are both full

module cross_set_box_overlap_suppress #(
	parameter int MAX_REFS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  csbos_pkg::in_item_t             item,
	output logic                            done,
	output csbos_pkg::out_item_t            result,
	input  logic                            cfg_wen,
	input  logic [csbos_pkg::THR_BITS-1:0]  cfg_wdata
);

	logic [csbos_pkg::THR_BITS-1:0] thr_q;
	logic                           q_full;
	logic                           q_empty;
	logic                           q_push;
	logic                           q_pop;
	csbos_pkg::cmd_t                q_in;
	csbos_pkg::cmd_t                q_head;

	// iou threshold in units of 1/256
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= csbos_pkg::THR_RESET;
		end else if (cfg_wen) begin
			thr_q <= cfg_wdata;
		end
	end

	// opcode decode and candidate area
	csbos_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.full   (q_full),
		.push   (q_push),
		.cmd    (q_in)
	);

	// decouples intake from the table walk
	csbos_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	// reference table, overlap walk and result register
	csbos_back #(
		.MAX_REFS (MAX_REFS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.thr    (thr_q),
		.empty  (q_empty),
		.head   (q_head),
		.pop    (q_pop),
		.done   (done),
		.result (result)
	);

endmodule

`default_nettype wire
